// ===== src/mts_pkg.sv =====
`timescale 1ns / 1ps
package mts_pkg;

	localparam int VAL_W  = 32;
	localparam int ENT_W  = 34;
	localparam int FILL_W = 9;

	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic signed [ENT_W-1:0] entry_t;
	typedef logic [1:0]              req_code_t;
	typedef logic [1:0]              status_t;
	typedef logic [FILL_W-1:0]       fill_t;

	// Request codes. The fourth code is a no-op that reports the unchanged state.
	localparam req_code_t REQ_PUSH = 2'd0;
	localparam req_code_t REQ_POP  = 2'd1;
	localparam req_code_t REQ_PEEK = 2'd2;
	localparam req_code_t REQ_NOP  = 2'd3;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	typedef struct packed {
		status_t status;
		value_t  out_value;
		value_t  min_value;
		logic    is_empty;
		fill_t   fill_count;
	} rsp_t;

endpackage

// ===== src/mts_req_if.sv =====
`timescale 1ns / 1ps
interface mts_req_if;
	import mts_pkg::*;

	logic      valid;
	logic      ready;
	req_code_t req_type;
	value_t    push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink   (input valid, input req_type, input push_value, output ready);

endinterface

// ===== src/mts_rsp_if.sv =====
`timescale 1ns / 1ps
interface mts_rsp_if;
	import mts_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	value_t  out_value;
	value_t  min_value;
	logic    is_empty;
	fill_t   fill_count;

	modport source (
		output valid, output status, output out_value, output min_value,
		output is_empty, output fill_count, input ready
	);
	modport sink (
		input valid, input status, input out_value, input min_value,
		input is_empty, input fill_count, output ready
	);

endinterface

// ===== src/mts_ram.sv =====
`timescale 1ns / 1ps
module mts_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== src/mts_core.sv =====
`timescale 1ns / 1ps
module mts_core #(
	parameter int STACK_DEPTH = 256
) (
	input  mts_pkg::req_code_t                 req_type,
	input  mts_pkg::value_t                    push_value,
	input  logic [$clog2(STACK_DEPTH+1)-1:0]   count,
	input  mts_pkg::entry_t                    top,
	input  mts_pkg::entry_t                    below,
	input  mts_pkg::value_t                    cur_min,
	output logic [$clog2(STACK_DEPTH+1)-1:0]   count_next,
	output mts_pkg::entry_t                    top_next,
	output mts_pkg::value_t                    min_next,
	output logic                               wr_en,
	output logic [$clog2(STACK_DEPTH)-1:0]     wr_addr,
	output mts_pkg::entry_t                    wr_data,
	output mts_pkg::rsp_t                      rsp
);
	import mts_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic          empty;
	logic          full;
	entry_t        min_e;
	entry_t        x_e;
	entry_t        push_enc;
	entry_t        pop_restore;
	logic          top_encoded;
	value_t        top_decoded;
	logic [CW-1:0] count_dec;

	assign empty       = (count == '0);
	assign full        = (count == CW'(STACK_DEPTH));
	assign min_e       = ENT_W'(cur_min);
	assign x_e         = ENT_W'(push_value);
	assign push_enc    = (x_e <<< 1) - min_e;
	assign pop_restore = (min_e <<< 1) - top;
	// An entry below the minimum marks a push that lowered the minimum.
	assign top_encoded = (top < min_e);
	assign top_decoded = top_encoded ? cur_min : top[VAL_W-1:0];
	assign count_dec   = count - CW'(1);

	assign wr_addr = count_dec[AW-1:0];
	assign wr_data = top;

	always_comb begin
		count_next    = count;
		top_next      = top;
		min_next      = cur_min;
		wr_en         = 1'b0;
		rsp.status    = ST_OK;
		rsp.out_value = '0;
		case (req_type)
			REQ_PUSH: begin
				if (full) begin
					rsp.status = ST_FULL;
				end else if (empty) begin
					top_next   = x_e;
					min_next   = push_value;
					count_next = CW'(1);
				end else begin
					// The old top moves down into the memory.
					wr_en      = 1'b1;
					count_next = count + CW'(1);
					if (x_e < min_e) begin
						top_next = push_enc;
						min_next = push_value;
					end else begin
						top_next = x_e;
					end
				end
			end
			REQ_POP: begin
				if (empty) begin
					rsp.status = ST_EMPTY;
				end else begin
					rsp.out_value = top_decoded;
					count_next    = count_dec;
					top_next      = below;
					if (count_dec == '0) begin
						min_next = '0;
					end else if (top_encoded) begin
						min_next = pop_restore[VAL_W-1:0];
					end
				end
			end
			REQ_PEEK: begin
				if (empty) begin
					rsp.status = ST_EMPTY;
				end else begin
					rsp.out_value = top_decoded;
				end
			end
			default: begin
			end
		endcase
		rsp.is_empty   = (count_next == '0);
		rsp.min_value  = rsp.is_empty ? '0 : min_next;
		rsp.fill_count = FILL_W'(count_next);
	end

endmodule

// ===== src/min_tracking_stack.sv =====
`timescale 1ns / 1ps
// Stack of signed 32-bit words that reports the smallest held value after
// every operation. A request word on req carries an operation (push, pop,
// peek or no-op) and a value to push. Each accepted request gives exactly
// one response word on rsp with a status, the popped or peeked value, the
// current minimum, an empty flag and the fill count after the operation.
//
// The response is registered: it is valid in the cycle after the request
// is accepted. Throughput is one request per cycle while responses are
// taken. The top entry and the entry just below it are held in registers
// (the second comes from the memory's registered read, prefetched every
// cycle), so a pop can follow any operation without a bubble.
//
// Reset empties the stack and clears the minimum; memory contents are not
// cleared since only entries below the fill count are ever used.
// When the receiver stalls, the response register holds its word and the
// request side is held off until the word is taken; a new request is taken
// in the same cycle that the waiting response leaves.
module min_tracking_stack #(
	parameter int STACK_DEPTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	mts_req_if.sink   req,
	mts_rsp_if.source rsp
);
	import mts_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// Stack state: fill count and minimum need reset, entries do not.
	logic [CW-1:0] count_q;
	value_t        min_q;
	entry_t        top_q;

	// Forwarding for a read of the address written in the same cycle.
	logic          fwd_q;
	entry_t        fwd_data_q;

	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic          accept;
	logic [CW-1:0] count_next;
	entry_t        top_next;
	value_t        min_next;
	logic          wr_en_core;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	rsp_t          rsp_next;
	entry_t        below;
	entry_t        ram_rd_data;
	logic [CW-1:0] count_after;
	logic [CW-1:0] below_idx;
	logic [AW-1:0] rd_addr;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign below = fwd_q ? fwd_data_q : ram_rd_data;

	mts_core #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_core (
		.req_type   (req.req_type),
		.push_value (req.push_value),
		.count      (count_q),
		.top        (top_q),
		.below      (below),
		.cur_min    (min_q),
		.count_next (count_next),
		.top_next   (top_next),
		.min_next   (min_next),
		.wr_en      (wr_en_core),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rsp        (rsp_next)
	);

	assign wr_en = accept && wr_en_core;

	// Always fetch the entry that will sit just below the top after this cycle.
	assign count_after = accept ? count_next : count_q;
	assign below_idx   = count_after - CW'(2);
	assign rd_addr     = below_idx[AW-1:0];

	mts_ram #(
		.WIDTH (ENT_W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			min_q       <= '0;
			fwd_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
			if (accept) begin
				count_q     <= count_next;
				min_q       <= min_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wr_data;
		if (accept) begin
			top_q <= top_next;
			rsp_q <= rsp_next;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_q.status;
	assign rsp.out_value  = rsp_q.out_value;
	assign rsp.min_value  = rsp_q.min_value;
	assign rsp.is_empty   = rsp_q.is_empty;
	assign rsp.fill_count = rsp_q.fill_count;

endmodule

// ===== tb/min_tracking_stack_check.sv =====
`timescale 1ns / 1ps
// Watches both channels of the stack, keeps a shadow copy of its contents and
// compares every response word with the word predicted for the oldest request.
module min_tracking_stack_check #(
	parameter int STACK_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	mts_req_if   req,
	mts_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);
	import mts_pkg::*;

	entry_t shadow_entries [STACK_DEPTH];
	int     shadow_fill;
	entry_t shadow_min;
	rsp_t   expected_words [$];

	initial fail_count = 0;

	// Applies one request to the shadow stack and returns the response it gives.
	function automatic rsp_t apply_request(req_code_t op, value_t x);
		rsp_t   w;
		entry_t top;
		entry_t x_e;
		w = '0;
		w.status = ST_OK;
		x_e = entry_t'(x);
		case (op)
			REQ_PUSH: begin
				if (shadow_fill >= STACK_DEPTH) begin
					w.status = ST_FULL;
				end else if (shadow_fill == 0) begin
					shadow_entries[0] = x_e;
					shadow_min = x_e;
					shadow_fill = 1;
				end else begin
					// A new minimum is stored encoded so that the old one can be
					// recovered when this entry is popped.
					if (x_e < shadow_min) begin
						shadow_entries[shadow_fill] = (x_e <<< 1) - shadow_min;
						shadow_min = x_e;
					end else begin
						shadow_entries[shadow_fill] = x_e;
					end
					shadow_fill++;
				end
			end
			REQ_POP, REQ_PEEK: begin
				if (shadow_fill == 0) begin
					w.status = ST_EMPTY;
				end else begin
					top = shadow_entries[shadow_fill - 1];
					w.out_value = (top < shadow_min) ? value_t'(shadow_min)
					                                 : value_t'(top);
					if (op == REQ_POP) begin
						if (top < shadow_min)
							shadow_min = (shadow_min <<< 1) - top;
						shadow_fill--;
						if (shadow_fill == 0)
							shadow_min = '0;
					end
				end
			end
			default: ;
		endcase
		w.min_value  = (shadow_fill == 0) ? value_t'(0) : value_t'(shadow_min);
		w.is_empty   = (shadow_fill == 0);
		w.fill_count = fill_t'(shadow_fill);
		return w;
	endfunction

	function automatic void note_failure(string what, rsp_t want, rsp_t got);
		fail_count++;
		if (fail_count <= 10)
			$display({"%0t: %s: expected st=%0d out=%0d min=%0d empty=%0b fill=%0d,",
				" got st=%0d out=%0d min=%0d empty=%0b fill=%0d"},
				$time, what, want.status, want.out_value, want.min_value, want.is_empty,
				want.fill_count, got.status, got.out_value, got.min_value, got.is_empty,
				got.fill_count);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t got;
		rsp_t want;
		if (!arst_n) begin
			shadow_fill = 0;
			shadow_min = '0;
			expected_words.delete();
			pending = 0;
		end else begin
			// The response leaving now belongs to an earlier request, so it is
			// checked before this edge's request is predicted.
			if (rsp.valid && rsp.ready) begin
				got.status     = rsp.status;
				got.out_value  = rsp.out_value;
				got.min_value  = rsp.min_value;
				got.is_empty   = rsp.is_empty;
				got.fill_count = rsp.fill_count;
				if (expected_words.size() == 0) begin
					note_failure("unexpected word", '0, got);
				end else begin
					want = expected_words.pop_front();
					if (got.status !== want.status || got.out_value !== want.out_value ||
					    got.min_value !== want.min_value || got.is_empty !== want.is_empty ||
					    got.fill_count !== want.fill_count)
						note_failure("mismatch", want, got);
				end
			end
			if (req.valid && req.ready)
				expected_words.push_back(apply_request(req.req_type, req.push_value));
			pending = expected_words.size();
		end
	end

endmodule

// ===== tb/min_tracking_stack_tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the min-tracking stack. The checker beside the block
// predicts and compares every response word; this module only produces request
// words, throttles the response side and decides pass or fail at the end.
module min_tracking_stack_tb;
	import mts_pkg::*;

	localparam int DEPTH      = 256;
	localparam int N_RANDOM   = 950;
	localparam int IDLE_LIMIT = 2000;

	localparam value_t VAL_MIN = 32'sh8000_0000;
	localparam value_t VAL_MAX = 32'sh7fff_ffff;

	logic clk;
	logic arst_n;

	mts_req_if req ();
	mts_rsp_if rsp ();

	int     fail_count;
	int     pending;
	bit     quiet;        // when set, neither side inserts idle cycles
	int     depth;        // entries the stack should hold, for steering stimulus only
	int     sent;
	int     idle_cycles;
	value_t last_pushed;

	min_tracking_stack #(.STACK_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	min_tracking_stack_check #(.STACK_DEPTH(DEPTH)) stack_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle stretches: most often none, otherwise of random length, the longest ones rarest.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Values lean toward the extremes, toward small numbers that give ties with
	// the minimum, and toward a falling run that keeps making new minimums.
	function automatic value_t pick_value();
		int     r;
		value_t v;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 4))
				0:       v = VAL_MIN;
				1:       v = VAL_MAX;
				2:       v = 0;
				3:       v = -1;
				default: v = 1;
			endcase
		end else if (r < 40) begin
			v = $urandom_range(0, 40);
			v = v - 20;
		end else if (r < 65) begin
			v = last_pushed - value_t'($urandom_range(0, 5000));
		end else begin
			v = $urandom;
		end
		return v;
	endfunction

	// Pushes dominate while the stack is shallow and give way to pops as it
	// gets deep, so the fill wanders without sticking at either end.
	function automatic req_code_t pick_op();
		int r;
		int push_share;
		r = $urandom_range(0, 99);
		push_share = (depth < 8) ? 55 : (depth > 200) ? 30 : 43;
		if (r < 4)
			return REQ_NOP;
		else if (r < 18)
			return REQ_PEEK;
		else if (r < 18 + push_share)
			return REQ_PUSH;
		return REQ_POP;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input req_code_t op, input value_t v);
		int gap;
		gap = idle_len();
		repeat (gap) begin
			req.valid      <= 1'b0;
			req.req_type   <= req_code_t'($urandom);
			req.push_value <= $urandom;
			@(negedge clk);
		end
		req.valid      <= 1'b1;
		req.req_type   <= op;
		req.push_value <= v;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		if (op == REQ_PUSH) begin
			last_pushed = v;
			if (depth < DEPTH)
				depth++;
		end else if (op == REQ_POP && depth > 0) begin
			depth--;
		end
		sent++;
	endtask

	// Holds the request side off until every outstanding response has arrived.
	task automatic wait_all_answered();
		req.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic mixed_run(input int n);
		repeat (n)
			send_word(pick_op(), pick_value());
	endtask

	// Response side: bursts of ready separated by random stalls.
	initial begin
		int run;
		int gap;
		rsp.ready = 1'b0;
		forever begin
			run = $urandom_range(1, 24);
			repeat (run) begin
				@(negedge clk);
				rsp.ready <= 1'b1;
			end
			gap = idle_len();
			repeat (gap) begin
				@(negedge clk);
				rsp.ready <= 1'b0;
			end
		end
	end

	// Ends the run if neither channel moves a word for too long.
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("min_tracking_stack_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int  target;
		int  seg;
		bit  full_done;
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.req_type   = REQ_NOP;
		req.push_value = '0;
		quiet          = 1'b0;
		depth          = 0;
		sent           = 0;
		idle_cycles    = 0;
		last_pushed    = 0;
		full_done      = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. Pop and peek on an empty stack must report the empty
		// status, and the unused request code must leave everything alone.
		send_word(REQ_POP, 32'sd7);
		send_word(REQ_PEEK, VAL_MAX);
		send_word(REQ_NOP, VAL_MIN);
		// The first push on an empty stack becomes the minimum unencoded; the
		// most negative value below the largest one gives the widest encoding.
		send_word(REQ_PUSH, VAL_MAX);
		send_word(REQ_PUSH, VAL_MIN);
		send_word(REQ_PEEK, 32'sd0);
		send_word(REQ_NOP, 32'sd3);
		send_word(REQ_PUSH, 32'sd0);
		// A value equal to the minimum is stored as it is, not encoded.
		send_word(REQ_PUSH, VAL_MIN);
		send_word(REQ_POP, 32'sd0);
		send_word(REQ_POP, 32'sd0);
		send_word(REQ_PEEK, 32'sd0);
		send_word(REQ_POP, 32'sd0);
		// This pop empties the stack, so the minimum goes back to zero.
		send_word(REQ_POP, 32'sd0);
		send_word(REQ_POP, 32'sd0);
		send_word(REQ_PUSH, -32'sd1);
		send_word(REQ_PUSH, 32'sd1);
		send_word(REQ_PUSH, -32'sd2);
		send_word(REQ_PUSH, VAL_MIN);
		send_word(REQ_POP, 32'sd0);
		send_word(REQ_POP, 32'sd0);
		send_word(REQ_POP, 32'sd0);
		send_word(REQ_POP, 32'sd0);

		// Let every response come home before the random part starts.
		wait_all_answered();

		target = sent + N_RANDOM;
		while (sent < target) begin
			quiet = ($urandom_range(0, 5) == 0);
			seg = $urandom_range(0, 9);
			if (!full_done && sent > target / 3) begin
				// Fill to the limit, try a few pushes that must be refused, then
				// drain completely with the odd peek mixed in.
				while (depth < DEPTH)
					send_word(REQ_PUSH, pick_value());
				repeat ($urandom_range(1, 3))
					send_word(REQ_PUSH, pick_value());
				send_word(REQ_PEEK, pick_value());
				while (depth > 0)
					send_word(($urandom_range(0, 7) == 0) ? REQ_PEEK : REQ_POP, pick_value());
				send_word(REQ_POP, pick_value());
				full_done = 1'b1;
			end else if (seg == 0) begin
				while (depth > 0)
					send_word(REQ_POP, pick_value());
				send_word(($urandom_range(0, 1) == 0) ? REQ_POP : REQ_PEEK, pick_value());
			end else begin
				mixed_run($urandom_range(10, 60));
				if (seg == 1)
					wait_all_answered();
			end
		end
		quiet = 1'b0;

		// Drain: no more requests, wait for the last responses, then keep
		// watching to catch any stray word.
		wait_all_answered();
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("min_tracking_stack_tb: PASS");
		else
			$display("min_tracking_stack_tb: FAIL");
		$finish;
	end

endmodule
